### rtl/erps_pkg.sv
`timescale 1ns / 1ps

package erps_pkg;

    localparam int MM_W      = 12;
    localparam int SPEED_W   = 10;
    localparam int OUT_CNT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;

    // speed [m/s] * t [ns] / 2e6 gives the one-way distance in mm
    localparam int unsigned HALF_MM_SCALE = 2000000;

    // 2e6 = 2^7 * 15625: drop 7 bits, then multiply by ceil(2^40 / 15625).
    // Exact for every shifted product below 4096 * 15625; anything at or
    // above that is out of range anyway.
    localparam int                    DIST_PRE_SH = 7;
    localparam int                    DIST_X_W    = 26;
    localparam int                    DIST_RCP_W  = 27;
    localparam int                    DIST_RCP_SH = 40;
    localparam logic [63:0]           DIST_LIMIT  = 64'd64000000;
    localparam logic [DIST_RCP_W-1:0] DIST_RCP    = 27'd70368745;

    localparam logic [MM_W-1:0]    MAX_VALID_RST = 12'd2000;
    localparam logic [SPEED_W-1:0] SPEED_RST     = 10'd343;
    localparam logic [MM_W-1:0]    MIN_START_RST = 12'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VALID = 2'd0,
        CFG_SPEED     = 2'd1,
        CFG_MIN_START = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_MEASURE = 2'd0,
        K_MISS    = 2'd1,
        K_CLEAR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_head;

    typedef struct packed {
        logic [MM_W-1:0]    max_valid;
        logic [SPEED_W-1:0] speed;
        logic [MM_W-1:0]    min_start;
    } t_cfg;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIST,
        B_UPDATE,
        B_AVG,
        B_AVG_WAIT,
        B_OUT
    } t_bstate;

endpackage

### rtl/echo_pulse_range_statistics.sv
`timescale 1ns / 1ps

// Ultrasonic time-of-flight range statistics. Each input transfer is either
// a measurement (echo flag plus echo high time in ns) or a clear command;
// each one yields exactly one output transfer carrying the current
// statistics. Distance is floor(speed * pulse_ns / 2e6) mm; it counts as a
// valid reading only with an echo and at or below max_valid_mm. Attempt and
// valid counters saturate; once the valid counter is full, later readings
// still update last/min/max but not the sum. A two-entry input queue lets a
// new item in while a result waits on the output register. A measurement
// goes through the multiply, distance, update, average and output states; a
// clear or a missed echo goes straight to average, and the divider is
// skipped when the valid count is zero. The next item is taken from the
// queue once the result is loaded into the output register. The distance
// comes from two registered multiplies; the average from one 12-step
// shift-subtract divider. Configuration writes must happen only while the
// block is idle; min_start_mm takes effect at the next clear.

module echo_pulse_range_statistics
    import erps_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int PULSE_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic                   i_echo_seen,
    input  logic [PULSE_WIDTH-1:0] i_pulse_ns,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_reading_valid,
    output logic [MM_W-1:0]        o_last_mm,
    output logic [MM_W-1:0]        o_min_mm,
    output logic [MM_W-1:0]        o_max_mm,
    output logic [MM_W-1:0]        o_average_mm,
    output logic [OUT_CNT_W-1:0]   o_attempt_count,
    output logic [OUT_CNT_W-1:0]   o_valid_count
);

    t_cfg                   r_cfg;
    t_head                  w_head;
    logic [PULSE_WIDTH-1:0] w_pulse;
    logic                   w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_valid <= MAX_VALID_RST;
            r_cfg.speed     <= SPEED_RST;
            r_cfg.min_start <= MIN_START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_VALID: r_cfg.max_valid <= i_cfg_data[MM_W-1:0];
                CFG_SPEED:     r_cfg.speed     <= i_cfg_data[SPEED_W-1:0];
                CFG_MIN_START: r_cfg.min_start <= i_cfg_data[MM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    erps_front #(
        .PULSE_WIDTH (PULSE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_echo_seen (i_echo_seen),
        .i_pulse_ns  (i_pulse_ns),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_pulse     (w_pulse)
    );

    erps_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .PULSE_WIDTH (PULSE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (w_head),
        .i_pulse         (w_pulse),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reading_valid (o_reading_valid),
        .o_last_mm       (o_last_mm),
        .o_min_mm        (o_min_mm),
        .o_max_mm        (o_max_mm),
        .o_average_mm    (o_average_mm),
        .o_attempt_count (o_attempt_count),
        .o_valid_count   (o_valid_count)
    );

endmodule

### rtl/erps_front.sv
`timescale 1ns / 1ps

module erps_front
    import erps_pkg::*;
#(
    parameter int PULSE_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic                   i_echo_seen,
    input  logic [PULSE_WIDTH-1:0] i_pulse_ns,
    input  logic                   i_pop,
    output t_head                  o_head,
    output logic [PULSE_WIDTH-1:0] o_pulse
);

    logic [1:0]             r_vld, n_vld;
    t_kind                  r_kind  [0:1];
    t_kind                  n_kind  [0:1];
    logic [PULSE_WIDTH-1:0] r_pulse [0:1];
    logic [PULSE_WIDTH-1:0] n_pulse [0:1];
    t_kind                  w_kind;
    logic                   w_push;

    always_comb begin
        priority if (i_action) begin
            w_kind = K_CLEAR;
        end else if (i_echo_seen) begin
            w_kind = K_MEASURE;
        end else begin
            w_kind = K_MISS;
        end
    end

    assign o_stall = r_vld[1];
    assign w_push  = i_valid && !r_vld[1];

    // two-entry queue, head always in slot 0
    always_comb begin
        n_vld   = r_vld;
        n_kind  = r_kind;
        n_pulse = r_pulse;
        if (i_pop) begin
            n_vld      = {1'b0, r_vld[1]};
            n_kind[0]  = r_kind[1];
            n_pulse[0] = r_pulse[1];
        end
        if (w_push) begin
            if (!n_vld[0]) begin
                n_vld[0]   = 1'b1;
                n_kind[0]  = w_kind;
                n_pulse[0] = i_pulse_ns;
            end else begin
                n_vld[1]   = 1'b1;
                n_kind[1]  = w_kind;
                n_pulse[1] = i_pulse_ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_pulse <= n_pulse;
    end

    assign o_head.valid = r_vld[0];
    assign o_head.kind  = r_kind[0];
    assign o_pulse      = r_pulse[0];

endmodule

### rtl/erps_div.sv
`timescale 1ns / 1ps

module erps_div
    import erps_pkg::*;
#(
    parameter int DW  = 44,
    parameter int DVW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DW-1:0]   i_dividend,
    input  logic [DVW-1:0]  i_divisor,
    output logic            o_done,
    output logic [MM_W-1:0] o_quot
);

    localparam int SHW   = DVW + MM_W - 1;
    localparam int CNT_W = $clog2(MM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [SHW-1:0]   r_sh;
    logic [MM_W-1:0]  r_q;
    logic             w_ge;

    assign w_ge = r_rem >= DW'(r_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring shift-subtract, one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_sh  <= {i_divisor, (MM_W - 1)'(0)};
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - DW'(r_sh);
            end
            r_q  <= {r_q[MM_W-2:0], w_ge};
            r_sh <= r_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_LAST && !i_start) |=> r_done)
        else $error("divider did not finish after last step");

endmodule

### rtl/erps_back.sv
`timescale 1ns / 1ps

module erps_back
    import erps_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int PULSE_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_head                  i_head,
    input  logic [PULSE_WIDTH-1:0] i_pulse,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_reading_valid,
    output logic [MM_W-1:0]        o_last_mm,
    output logic [MM_W-1:0]        o_min_mm,
    output logic [MM_W-1:0]        o_max_mm,
    output logic [MM_W-1:0]        o_average_mm,
    output logic [OUT_CNT_W-1:0]   o_attempt_count,
    output logic [OUT_CNT_W-1:0]   o_valid_count
);

    localparam int SUM_W  = COUNT_WIDTH + MM_W;
    localparam int PROD_W = PULSE_WIDTH + SPEED_W;

    t_bstate r_state, n_state;

    logic [PULSE_WIDTH-1:0] r_pulse, n_pulse;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [PROD_W-1:0]      w_prod;
    logic [MM_W-1:0]        r_dist, n_dist;
    logic                   r_far, n_far;
    logic                   r_ok, n_ok;
    logic [MM_W-1:0]        r_avg, n_avg;

    logic [MM_W-1:0]        r_last, n_last;
    logic [MM_W-1:0]        r_min, n_min;
    logic [MM_W-1:0]        r_max, n_max;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [COUNT_WIDTH-1:0] r_attempts, n_attempts;
    logic [COUNT_WIDTH-1:0] r_accepted, n_accepted;

    logic                   r_out_valid, n_out_valid;
    logic                   r_o_ok, n_o_ok;
    logic [MM_W-1:0]        r_o_last, n_o_last;
    logic [MM_W-1:0]        r_o_min, n_o_min;
    logic [MM_W-1:0]        r_o_max, n_o_max;
    logic [MM_W-1:0]        r_o_avg, n_o_avg;
    logic [OUT_CNT_W-1:0]   r_o_att, n_o_att;
    logic [OUT_CNT_W-1:0]   r_o_acc, n_o_acc;

    logic [63:0]                    w_x;
    logic                           w_far;
    logic [DIST_X_W+DIST_RCP_W-1:0] w_rcp_prod;
    logic [MM_W-1:0]                w_dist;

    logic                   w_div_start;
    logic                   w_div_done;
    logic [MM_W-1:0]        w_div_quot;

    assign w_prod = i_cfg.speed * r_pulse;

    // distance by reciprocal multiplication; w_far flags anything above 4095 mm
    assign w_x        = 64'(r_prod[PROD_W-1:DIST_PRE_SH]);
    assign w_far      = w_x >= DIST_LIMIT;
    assign w_rcp_prod = w_x[DIST_X_W-1:0] * DIST_RCP;
    assign w_dist     = w_rcp_prod[DIST_RCP_SH +: MM_W];

    erps_div #(
        .DW  (SUM_W),
        .DVW (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_accepted),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_pulse        = r_pulse;
        n_prod         = r_prod;
        n_dist         = r_dist;
        n_far          = r_far;
        n_ok           = r_ok;
        n_avg          = r_avg;
        n_last         = r_last;
        n_min          = r_min;
        n_max          = r_max;
        n_sum          = r_sum;
        n_attempts     = r_attempts;
        n_accepted     = r_accepted;
        n_out_valid    = r_out_valid && i_stall;
        n_o_ok         = r_o_ok;
        n_o_last       = r_o_last;
        n_o_min        = r_o_min;
        n_o_max        = r_o_max;
        n_o_avg        = r_o_avg;
        n_o_att        = r_o_att;
        n_o_acc        = r_o_acc;
        o_pop          = 1'b0;
        w_div_start    = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_pulse = i_pulse;
                    n_ok    = 1'b0;
                    unique case (i_head.kind)
                        K_CLEAR: begin
                            n_min      = i_cfg.min_start;
                            n_max      = '0;
                            n_sum      = '0;
                            n_attempts = '0;
                            n_accepted = '0;
                            n_state    = B_AVG;
                        end
                        K_MISS: begin
                            if (r_attempts != '1) begin
                                n_attempts = r_attempts + 1'b1;
                            end
                            n_state = B_AVG;
                        end
                        K_MEASURE: begin
                            if (r_attempts != '1) begin
                                n_attempts = r_attempts + 1'b1;
                            end
                            n_state = B_MUL;
                        end
                        default: begin
                            n_state = B_AVG;
                        end
                    endcase
                end
            end
            B_MUL: begin
                n_prod  = w_prod;
                n_state = B_DIST;
            end
            B_DIST: begin
                n_dist  = w_dist;
                n_far   = w_far;
                n_state = B_UPDATE;
            end
            B_UPDATE: begin
                if (!r_far && r_dist <= i_cfg.max_valid) begin
                    n_ok   = 1'b1;
                    n_last = r_dist;
                    if (r_dist < r_min) begin
                        n_min = r_dist;
                    end
                    if (r_dist > r_max) begin
                        n_max = r_dist;
                    end
                    // a full valid count freezes the sum as well
                    if (r_accepted != '1) begin
                        n_accepted = r_accepted + 1'b1;
                        n_sum      = r_sum + SUM_W'(r_dist);
                    end
                end
                n_state = B_AVG;
            end
            B_AVG: begin
                if (r_accepted == '0) begin
                    n_avg   = '0;
                    n_state = B_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = B_AVG_WAIT;
                end
            end
            B_AVG_WAIT: begin
                if (w_div_done) begin
                    n_avg   = w_div_quot;
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_ok;
                    n_o_last    = r_last;
                    n_o_min     = r_min;
                    n_o_max     = r_max;
                    n_o_avg     = r_avg;
                    n_o_att     = OUT_CNT_W'(r_attempts);
                    n_o_acc     = OUT_CNT_W'(r_accepted);
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_min       <= MIN_START_RST;
            r_max       <= '0;
            r_sum       <= '0;
            r_attempts  <= '0;
            r_accepted  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_attempts  <= n_attempts;
            r_accepted  <= n_accepted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pulse  <= n_pulse;
        r_prod   <= n_prod;
        r_dist   <= n_dist;
        r_far    <= n_far;
        r_ok     <= n_ok;
        r_avg    <= n_avg;
        r_o_ok   <= n_o_ok;
        r_o_last <= n_o_last;
        r_o_min  <= n_o_min;
        r_o_max  <= n_o_max;
        r_o_avg  <= n_o_avg;
        r_o_att  <= n_o_att;
        r_o_acc  <= n_o_acc;
    end

    assign o_valid         = r_out_valid;
    assign o_reading_valid = r_o_ok;
    assign o_last_mm       = r_o_last;
    assign o_min_mm        = r_o_min;
    assign o_max_mm        = r_o_max;
    assign o_average_mm    = r_o_avg;
    assign o_attempt_count = r_o_att;
    assign o_valid_count   = r_o_acc;

    a_min_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accepted != '0) |-> (r_min <= r_max))
        else $error("min above max with accepted readings");

    a_acc_le_att : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accepted <= r_attempts)
        else $error("valid count exceeds attempt count");

endmodule

### tb/sv/tb_echo_pulse_range_statistics.sv
`timescale 1ns / 1ps

module tb_echo_pulse_range_statistics;
    import erps_pkg::*;

    localparam int PULSE_W     = 24;
    localparam int SUM_W       = OUT_CNT_W + MM_W;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 64;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 200;

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    typedef struct packed {
        logic                 reading_valid;
        logic [MM_W-1:0]      last_mm;
        logic [MM_W-1:0]      min_mm;
        logic [MM_W-1:0]      max_mm;
        logic [MM_W-1:0]      average_mm;
        logic [OUT_CNT_W-1:0] attempt_count;
        logic [OUT_CNT_W-1:0] valid_count;
    } t_stats;

    class range_stats_board;
        logic [MM_W-1:0]      max_valid;
        logic [SPEED_W-1:0]   speed;
        logic [MM_W-1:0]      min_start;
        logic [MM_W-1:0]      last_d;
        logic [MM_W-1:0]      min_d;
        logic [MM_W-1:0]      max_d;
        logic [SUM_W-1:0]     dist_sum;
        logic [OUT_CNT_W-1:0] attempts;
        logic [OUT_CNT_W-1:0] accepted;
        t_stats               stats_due[$];
        int                   errors;

        function new();
            max_valid = MAX_VALID_RST;
            speed     = SPEED_RST;
            min_start = MIN_START_RST;
            last_d    = '0;
            errors    = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            min_d    = min_start;
            max_d    = '0;
            dist_sum = '0;
            attempts = '0;
            accepted = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MAX_VALID: max_valid = data[MM_W-1:0];
                CFG_SPEED:     speed = data[SPEED_W-1:0];
                CFG_MIN_START: min_start = data[MM_W-1:0];
                default: ;
            endcase
        endfunction

        // updates the statistics for one accepted input transfer
        function void note_request(logic act, logic echo, logic [PULSE_W-1:0] pulse);
            t_stats          res;
            longint unsigned dist_mm;
            logic            ok;
            ok = 1'b0;
            if (act == ACT_CLEAR) begin
                clear_stats();
            end else begin
                if (attempts != '1) attempts++;
                if (echo) begin
                    dist_mm = (64'(speed) * 64'(pulse)) / 64'(HALF_MM_SCALE);
                    if (dist_mm <= 64'(max_valid)) begin
                        ok     = 1'b1;
                        last_d = MM_W'(dist_mm);
                        if (last_d < min_d) min_d = last_d;
                        if (last_d > max_d) max_d = last_d;
                        // sum freezes together with the saturated count
                        if (accepted != '1) begin
                            accepted++;
                            dist_sum += SUM_W'(dist_mm);
                        end
                    end
                end
            end
            res.reading_valid = ok;
            res.last_mm       = last_d;
            res.min_mm        = min_d;
            res.max_mm        = max_d;
            res.average_mm    = (accepted != 0) ? MM_W'(dist_sum / accepted) : '0;
            res.attempt_count = attempts;
            res.valid_count   = accepted;
            stats_due.push_back(res);
        endfunction

        task report(string what);
            errors++;
            // keep the log bounded on a badly broken block
            if (errors <= 100) $display("mismatch: %s", what);
        endtask

        task check_stats(t_stats got);
            t_stats want;
            if (stats_due.size() == 0) begin
                report("result transfer with no expectation pending");
                return;
            end
            want = stats_due.pop_front();
            if (got.reading_valid != want.reading_valid)
                report($sformatf("reading_valid got %0d want %0d",
                                 got.reading_valid, want.reading_valid));
            if (got.last_mm != want.last_mm)
                report($sformatf("last_mm got %0d want %0d", got.last_mm, want.last_mm));
            if (got.min_mm != want.min_mm)
                report($sformatf("min_mm got %0d want %0d", got.min_mm, want.min_mm));
            if (got.max_mm != want.max_mm)
                report($sformatf("max_mm got %0d want %0d", got.max_mm, want.max_mm));
            if (got.average_mm != want.average_mm)
                report($sformatf("average_mm got %0d want %0d",
                                 got.average_mm, want.average_mm));
            if (got.attempt_count != want.attempt_count)
                report($sformatf("attempt_count got %0d want %0d",
                                 got.attempt_count, want.attempt_count));
            if (got.valid_count != want.valid_count)
                report($sformatf("valid_count got %0d want %0d",
                                 got.valid_count, want.valid_count));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_action;
    logic                 i_echo_seen;
    logic [PULSE_W-1:0]   i_pulse_ns;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_reading_valid;
    logic [MM_W-1:0]      o_last_mm;
    logic [MM_W-1:0]      o_min_mm;
    logic [MM_W-1:0]      o_max_mm;
    logic [MM_W-1:0]      o_average_mm;
    logic [OUT_CNT_W-1:0] o_attempt_count;
    logic [OUT_CNT_W-1:0] o_valid_count;

    range_stats_board board;
    bit               calm = 1'b0;
    int               hold_requests = 0;

    echo_pulse_range_statistics #(
        .COUNT_WIDTH(OUT_CNT_W),
        .PULSE_WIDTH(PULSE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_echo_seen    (i_echo_seen),
        .i_pulse_ns     (i_pulse_ns),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_reading_valid(o_reading_valid),
        .o_last_mm      (o_last_mm),
        .o_min_mm       (o_min_mm),
        .o_max_mm       (o_max_mm),
        .o_average_mm   (o_average_mm),
        .o_attempt_count(o_attempt_count),
        .o_valid_count  (o_valid_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // result side: random stall bursts, plus long holds on request
    initial begin
        int stall_left;
        int holds_served;
        i_stall      = 1'b0;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_stats seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{o_reading_valid, o_last_mm, o_min_mm, o_max_mm, o_average_mm,
                     o_attempt_count, o_valid_count};
            board.check_stats(seen);
        end
    end

    // smallest pulse that converts to mm at the current speed, shifted by offset
    function automatic logic [PULSE_W-1:0] pulse_for_mm(longint unsigned mm, int offset);
        longint unsigned q;
        longint          p;
        if (board.speed == 0) return PULSE_W'($urandom);
        q = (mm * HALF_MM_SCALE + board.speed - 1) / board.speed;
        p = longint'(q) + offset;
        if (p < 0) p = 0;
        if (p > longint'(PULSE_MAX)) p = longint'(PULSE_MAX);
        return PULSE_W'(p);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic act, logic echo, logic [PULSE_W-1:0] pulse);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_action    = act;
        i_echo_seen = echo;
        i_pulse_ns  = pulse;
        do @(posedge i_clk); while (o_stall);
        board.note_request(act, echo, pulse);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_random_item();
        logic [PULSE_W-1:0] pulse;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            send_item(ACT_CLEAR, 1'($urandom), PULSE_W'($urandom));
        end else begin
            if (pick < 40)
                pulse = pulse_for_mm(board.max_valid + $urandom_range(0, 1),
                                     int'($urandom_range(0, 4)) - 2);
            else if (pick < 70)
                pulse = pulse_for_mm($urandom_range(0, board.max_valid), 0);
            else
                pulse = PULSE_W'($urandom);
            send_item(ACT_MEASURE, $urandom_range(0, 9) != 0, pulse);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic wait_drain();
        while (board.stats_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        board       = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MAX_VALID;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_action    = ACT_MEASURE;
        i_echo_seen = 1'b0;
        i_pulse_ns  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset configuration
        send_item(ACT_MEASURE, 1'b0, PULSE_MAX);
        send_item(ACT_MEASURE, 1'b1, '0);
        send_item(ACT_MEASURE, 1'b1, PULSE_MAX);
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(2000, 0));
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(2001, 0));
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(2000, -1));
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(1000, 0));
        send_item(ACT_CLEAR, 1'b1, PULSE_MAX);
        send_item(ACT_CLEAR, 1'b0, '0);
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(500, 0));
        send_item(ACT_MEASURE, 1'b0, '0);

        // widest range, fastest speed; new min start shows only after a clear
        wait_drain();
        write_reg(CFG_MAX_VALID, 12'd4095);
        write_reg(CFG_SPEED, 12'd1023);
        write_reg(CFG_MIN_START, 12'd0);
        send_item(ACT_MEASURE, 1'b1, PULSE_MAX);
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(4095, 0));
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(4096, 0));
        send_item(ACT_CLEAR, 1'b0, PULSE_MAX);
        send_item(ACT_MEASURE, 1'b1, pulse_for_mm(7, 0));

        // zero speed turns every pulse into 0 mm
        wait_drain();
        write_reg(CFG_SPEED, 12'd0);
        write_reg(CFG_MAX_VALID, 12'd0);
        write_reg(CFG_MIN_START, 12'd4095);
        send_item(ACT_MEASURE, 1'b1, PULSE_MAX);
        send_item(ACT_CLEAR, 1'b1, '0);
        send_item(ACT_MEASURE, 1'b1, 24'h555555);
        send_item(ACT_MEASURE, 1'b1, 24'hAAAAAA);
        send_item(ACT_MEASURE, 1'b0, PULSE_MAX);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drain();
            write_reg(CFG_MAX_VALID, ph == 1 ? 12'd4095 :
                                     ph == 3 ? 12'd0 : 12'($urandom_range(100, 4095)));
            write_reg(CFG_SPEED, ph == 2 ? 12'd1023 :
                                 ph == 4 ? 12'(SPEED_RST) : 12'($urandom_range(1, 1023)));
            write_reg(CFG_MIN_START, ph == 1 ? 12'd0 :
                                     ph == 3 ? 12'd4095 : 12'($urandom_range(0, 4095)));
            calm = (ph == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph == 2) hold_requests++;
                if (n == PHASE_ITEMS / 2 && ph == 4) wait_drain();
                send_random_item();
            end
        end

        wait_drain();
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
